[hw/rtl/fcp_pkg.sv]
`timescale 1ns / 1ps

package fcp_pkg;

    // Default geometry of the datagram stream
    localparam int CHUNK_BYTES_DEF = 1400;
    localparam int SIZE_BITS_DEF   = 24;

    // Fixed header layout
    localparam int HDR_BYTES  = 16;
    localparam int HDR_IDX_W  = $clog2(HDR_BYTES + 1);
    localparam int COUNT_BITS = 16;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        frame_start;
        logic [23:0] frame_bytes;
        logic [31:0] frame_number;
        logic [7:0]  stream_kind;
        logic [7:0]  capture_mode;
    } fcp_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       datagram_last;
        logic       run_last;
    } fcp_out_t;

endpackage

[hw/rtl/fcp_if.sv]
`timescale 1ns / 1ps

interface fcp_in_if import fcp_pkg::*; ();
    logic    valid;
    logic    ready;
    fcp_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fcp_out_if import fcp_pkg::*; ();
    logic     valid;
    logic     ready;
    fcp_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/fcp_ceil_div.sv]
`timescale 1ns / 1ps

// Chunk count by reciprocal multiplication, registered on start.
// total = floor(dividend / CHUNK_BYTES) + 1, kept modulo 2^COUNT_BITS.
// The reciprocal is rounded up with enough fraction bits that the floor is
// exact for every dividend below 2^SIZE_BITS.
module fcp_ceil_div import fcp_pkg::*; #(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
    parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SIZE_BITS-1:0]  dividend,
    output logic [COUNT_BITS-1:0] total
);

    localparam int CW  = $clog2(CHUNK_BYTES + 1);
    localparam int SH  = SIZE_BITS + CW;
    localparam int RW  = SIZE_BITS + 2;
    localparam int PRW = SIZE_BITS + RW;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SH) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_WIDE);

    logic [PRW-1:0]        product;
    logic [COUNT_BITS-1:0] quot;
    logic [COUNT_BITS-1:0] total_reg, total_next;

    assign product = PRW'(dividend) * PRW'(RECIP);
    assign quot    = COUNT_BITS'(product >> SH);
    assign total   = total_reg;

    always_comb
    begin
        total_next = total_reg;
        if (start)
        begin
            total_next = quot + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

endmodule

[hw/rtl/frame_chunk_packetizer.sv]
`timescale 1ns / 1ps

// Channel    Dir   Request                      Handshake
// frames     sink  one payload byte + metadata  valid/ready, taken when both high
// datagrams  src   one header or payload byte   valid/ready, taken when both high
//
// A payload byte inside a datagram is held in an input register; once the output
// register is free, its result is registered there, and a new byte is taken as
// the held one retires. A byte that opens a datagram follows 16 header bytes.
// A frame start first latches the metadata and the chunk total,
// which comes from a reciprocal multiply of the frame size.
// Reset clears the frame state; the block then drops bytes until a frame start.
// A stall on datagrams holds the output register and backs up into frames.
module frame_chunk_packetizer import fcp_pkg::*; #(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
    parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fcp_in_if.sink    frames,
    fcp_out_if.source datagrams
);

    localparam int PW  = $clog2(CHUNK_BYTES + 1);
    localparam int HIW = $clog2(HDR_BYTES);

    // Request held for processing
    logic                  hold_valid_reg, hold_valid_next;
    logic                  hold_start_reg, hold_start_next;
    fcp_in_t               hold_reg,       hold_next;
    logic [HDR_IDX_W-1:0]  hdr_idx_reg,    hdr_idx_next;

    // Frame state
    logic                  in_frame_reg,   in_frame_next;
    logic [SIZE_BITS-1:0]  bytes_left_reg, bytes_left_next;
    logic [PW-1:0]         pos_reg,        pos_next;
    logic [COUNT_BITS-1:0] chunk_cnt_reg,  chunk_cnt_next;
    logic [31:0]           frame_tag_reg,  frame_tag_next;
    logic [7:0]            stream_tag_reg, stream_tag_next;
    logic [7:0]            mode_tag_reg,   mode_tag_next;

    // Output register
    logic                  out_valid_reg,  out_valid_next;
    fcp_out_t              out_reg,        out_next;

    logic                  div_start;
    logic [COUNT_BITS-1:0] chunk_total;
    logic [SIZE_BITS-1:0]  size_w;
    logic [31:0]           seg_bytes;
    logic [HDR_BYTES*8-1:0] hdr_vec;
    logic [7:0]            hdr_byte;
    logic [PW-1:0]         pos_inc;
    logic [SIZE_BITS-1:0]  bytes_dec;
    logic                  chunk_end;
    logic                  out_free;
    logic                  emit;
    logic                  done;
    logic                  accept;

    fcp_ceil_div #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .SIZE_BITS   (SIZE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (size_w - SIZE_BITS'(1)),
        .total    (chunk_total)
    );

    // Mask the frame size to the configured width
    assign size_w = SIZE_BITS'(hold_reg.frame_bytes);

    // This chunk's length: the full chunk, or whatever is left of the frame
    assign seg_bytes = (32'(bytes_left_reg) < 32'(CHUNK_BYTES)) ?
                       32'(bytes_left_reg) : 32'(CHUNK_BYTES);

    // Header, byte 0 in the top bits
    assign hdr_vec  = {frame_tag_reg, chunk_cnt_reg, chunk_total, seg_bytes,
                       stream_tag_reg, mode_tag_reg, 16'h0000};
    assign hdr_byte = hdr_vec[(HDR_BYTES*8-1) - 8*hdr_idx_reg[HIW-1:0] -: 8];

    assign pos_inc   = pos_reg + PW'(1);
    assign bytes_dec = bytes_left_reg - SIZE_BITS'(1);
    assign chunk_end = (pos_inc >= PW'(CHUNK_BYTES)) || (bytes_dec == '0);

    assign out_free = !out_valid_reg || datagrams.ready;

    // Take a new request when nothing is held or the held one retires now
    assign frames.ready = !hold_valid_reg || done;
    assign accept       = frames.valid && frames.ready;

    assign datagrams.valid = out_valid_reg;
    assign datagrams.data  = out_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_start_next = hold_start_reg;
        hold_next       = hold_reg;
        hdr_idx_next    = hdr_idx_reg;
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        pos_next        = pos_reg;
        chunk_cnt_next  = chunk_cnt_reg;
        frame_tag_next  = frame_tag_reg;
        stream_tag_next = stream_tag_reg;
        mode_tag_next   = mode_tag_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        div_start       = 1'b0;
        emit            = 1'b0;
        done            = 1'b0;

        if (hold_valid_reg)
        begin
            if (hold_start_reg)
            begin
                // Latch the frame metadata; an unfinished frame is abandoned
                frame_tag_next  = hold_reg.frame_number;
                stream_tag_next = hold_reg.stream_kind;
                mode_tag_next   = hold_reg.capture_mode;
                bytes_left_next = size_w;
                pos_next        = '0;
                chunk_cnt_next  = '0;
                in_frame_next   = (size_w != '0);
                div_start       = (size_w != '0);
                hold_start_next = 1'b0;
            end
            else if (!in_frame_reg)
            begin
                // drop a byte outside any frame
                done = 1'b1;
            end
            else if (out_free)
            begin
                emit = 1'b1;
                if ((pos_reg == '0) && (hdr_idx_reg != HDR_IDX_W'(HDR_BYTES)))
                begin
                    out_next.out_byte      = hdr_byte;
                    out_next.is_header     = 1'b1;
                    out_next.datagram_last = 1'b0;
                    out_next.run_last      = 1'b0;
                    hdr_idx_next           = hdr_idx_reg + HDR_IDX_W'(1);
                end
                else
                begin
                    out_next.out_byte      = hold_reg.payload_byte;
                    out_next.is_header     = 1'b0;
                    out_next.datagram_last = chunk_end;
                    out_next.run_last      = 1'b1;
                    hdr_idx_next           = '0;
                    bytes_left_next        = bytes_dec;
                    pos_next               = chunk_end ? '0 : pos_inc;
                    if (chunk_end)
                    begin
                        chunk_cnt_next = chunk_cnt_reg + COUNT_BITS'(1);
                    end
                    if (bytes_dec == '0)
                    begin
                        in_frame_next = 1'b0;
                    end
                    done = 1'b1;
                end
            end
        end

        if (accept)
        begin
            hold_valid_next = 1'b1;
            hold_next       = frames.data;
            hold_start_next = frames.data.frame_start;
        end
        else if (done)
        begin
            hold_valid_next = 1'b0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (datagrams.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            hold_start_reg <= 1'b0;
            hdr_idx_reg    <= '0;
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= '0;
            pos_reg        <= '0;
            chunk_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            hold_start_reg <= hold_start_next;
            hdr_idx_reg    <= hdr_idx_next;
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            pos_reg        <= pos_next;
            chunk_cnt_reg  <= chunk_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg       <= hold_next;
        frame_tag_reg  <= frame_tag_next;
        stream_tag_reg <= stream_tag_next;
        mode_tag_reg   <= mode_tag_next;
        out_reg        <= out_next;
    end

    // An open frame always has bytes left to send
    a_frame_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (bytes_left_reg != '0))
        else $error("open frame with no bytes left");

    // Position within a datagram stays below the chunk size
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < PW'(CHUNK_BYTES))
        else $error("chunk position out of range");

    // An emitted header byte is registered in the output register as a header byte
    a_header_run: assert property (@(posedge clk) disable iff (!rst_n)
        emit && out_next.is_header |=> out_valid_reg && out_reg.is_header)
        else $error("header byte not registered");

endmodule

[tb/tb_frame_chunk_packetizer.sv]
`timescale 1ns / 1ps

// Checks the frame packetizer end to end. A stream of payload-byte requests
// goes in through the frames channel. A predictor models the frame and chunk
// bookkeeping and queues the header and payload bytes each request should
// produce. A checker process pops that queue for every byte taken from the
// datagrams channel. Both sides idle at random, with some stretches of no idling.
module tb_frame_chunk_packetizer import fcp_pkg::*; ();

    localparam int CHUNK        = CHUNK_BYTES_DEF;
    localparam int RANDOM_ITEMS = 330;
    localparam int TAIL_CYCLES  = 64;      // frame-start latch + header + margin
    localparam int CYCLE_LIMIT  = 5000000;
    localparam int MAX_REPORTS  = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    fcp_in_if  frames_ch ();
    fcp_out_if datagrams_ch ();

    // Drive the channel from local registers so every input is known at time 0
    logic    push_valid = 1'b0;
    fcp_in_t push_req   = '0;
    logic    take_ready = 1'b0;

    assign frames_ch.valid    = push_valid;
    assign frames_ch.data     = push_req;
    assign datagrams_ch.ready = take_ready;

    frame_chunk_packetizer #(
        .CHUNK_BYTES (CHUNK),
        .SIZE_BITS   (SIZE_BITS_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frames    (frames_ch),
        .datagrams (datagrams_ch)
    );

    // Predicted datagram stream, oldest byte first
    fcp_out_t bytes_due[$];

    // Predictor copy of the frame state
    logic        frame_open;
    logic [23:0] bytes_remaining;
    logic [10:0] chunk_fill;
    logic [15:0] seg_index;
    logic [15:0] chunk_count;
    logic [31:0] tag_frame;
    logic [7:0]  tag_stream;
    logic [7:0]  tag_mode;

    int requests_sent;
    int requests_dropped;
    int frames_opened;
    int datagrams_due;
    int results_seen;
    int mismatch_count;
    int cycle_count;
    bit src_quiet;
    bit sink_quiet;
    int sink_stall_left;

    // Work out the bytes one accepted request produces; return how many
    function automatic int packetize_byte(input fcp_in_t req);
        logic [7:0]  hdr [HDR_BYTES];
        logic [31:0] seg_len;
        fcp_out_t    r;
        logic        seg_end;
        int          n;

        n = 0;

        // Latch metadata on a frame start; this also abandons an open frame
        if (req.frame_start)
        begin
            tag_frame       = req.frame_number;
            tag_stream      = req.stream_kind;
            tag_mode        = req.capture_mode;
            bytes_remaining = req.frame_bytes;
            chunk_fill      = '0;
            seg_index       = '0;
            chunk_count     = 16'((int'(req.frame_bytes) + CHUNK - 1) / CHUNK);
            frame_open      = (req.frame_bytes != 0);
            if (frame_open)
                frames_opened++;
        end

        // Drop bytes outside a frame, including the byte of an empty frame
        if (!frame_open)
            return 0;

        // Open a datagram: emit the 16-byte header ahead of the payload byte
        if (chunk_fill == 0)
        begin
            seg_len = (int'(bytes_remaining) < CHUNK) ? 32'(bytes_remaining) : 32'(CHUNK);
            hdr[0]  = tag_frame[31:24];
            hdr[1]  = tag_frame[23:16];
            hdr[2]  = tag_frame[15:8];
            hdr[3]  = tag_frame[7:0];
            hdr[4]  = seg_index[15:8];
            hdr[5]  = seg_index[7:0];
            hdr[6]  = chunk_count[15:8];
            hdr[7]  = chunk_count[7:0];
            hdr[8]  = seg_len[31:24];
            hdr[9]  = seg_len[23:16];
            hdr[10] = seg_len[15:8];
            hdr[11] = seg_len[7:0];
            hdr[12] = tag_stream;
            hdr[13] = tag_mode;
            hdr[14] = 8'h00;
            hdr[15] = 8'h00;
            for (int i = 0; i < HDR_BYTES; i++)
            begin
                r.out_byte      = hdr[i];
                r.is_header     = 1'b1;
                r.datagram_last = 1'b0;
                r.run_last      = 1'b0;
                bytes_due.insert(bytes_due.size(), r);
                n++;
            end
        end

        // Advance the counters; close the datagram at a full chunk or frame end
        bytes_remaining = bytes_remaining - 24'd1;
        chunk_fill      = chunk_fill + 11'd1;
        seg_end         = (int'(chunk_fill) >= CHUNK) || (bytes_remaining == 0);
        if (seg_end)
        begin
            chunk_fill = '0;
            seg_index  = seg_index + 16'd1;
            datagrams_due++;
        end

        r.out_byte      = req.payload_byte;
        r.is_header     = 1'b0;
        r.datagram_last = seg_end;
        r.run_last      = 1'b1;
        bytes_due.insert(bytes_due.size(), r);
        n++;

        if (bytes_remaining == 0)
            frame_open = 1'b0;

        return n;
    endfunction

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    // Mostly the defined codes (0 color/close, 1 depth/far), sometimes anything
    function automatic logic [7:0] pick_tag();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
    endfunction

    function automatic fcp_in_t request_of(input logic [7:0] payload, input logic start,
                                           input logic [23:0] size, input logic [31:0] number,
                                           input logic [7:0] kind, input logic [7:0] mode);
        fcp_in_t req;

        req.payload_byte = payload;
        req.frame_start  = start;
        req.frame_bytes  = size;
        req.frame_number = number;
        req.stream_kind  = kind;
        req.capture_mode = mode;
        return req;
    endfunction

    // Metadata fields carry noise on requests that do not start a frame
    function automatic fcp_in_t random_request(input logic start, input logic [23:0] size);
        return request_of(8'($urandom), start, start ? size : 24'($urandom),
                          $urandom, pick_tag(), pick_tag());
    endfunction

    // Send one request, idling first; report how many bytes it should produce
    task automatic send_request(input fcp_in_t req, output int produced);
        int gap;

        if (requests_sent % 32 == 0)
            src_quiet = ($urandom_range(0, 3) == 0);
        gap = draw_gap(src_quiet);
        if (gap > 0)
        begin
            push_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push_valid <= 1'b1;
        push_req   <= req;
        do
            @(posedge clk);
        while (!(push_valid && frames_ch.ready));
        produced = packetize_byte(req);
        requests_sent++;
        if (produced == 0)
            requests_dropped++;
    endtask

    task automatic send_frame(input logic [23:0] size, input int count);
        int produced;

        for (int i = 0; i < count; i++)
            send_request(random_request(i == 0, size), produced);
    endtask

    task automatic send_one(input fcp_in_t req);
        int produced;

        send_request(req, produced);
    endtask

    task automatic report_mismatch(input string what, input fcp_out_t exp,
                                   input fcp_out_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("[%0t] %s: expected byte=%02h hdr=%b last=%b run=%b",
                     $realtime, what, exp.out_byte, exp.is_header, exp.datagram_last,
                     exp.run_last);
            $display("    got byte=%02h hdr=%b last=%b run=%b",
                     got.out_byte, got.is_header, got.datagram_last, got.run_last);
        end
    endtask

    // Check each byte taken from the datagrams channel, then draw the next stall
    always @(posedge clk)
    begin : take_datagrams
        fcp_out_t exp;
        fcp_out_t got;
        int       stall;

        if (rst_n)
        begin
            if (datagrams_ch.valid && take_ready)
            begin
                got = datagrams_ch.data;
                results_seen++;
                if (bytes_due.size() == 0)
                    report_mismatch("unexpected byte", '0, got);
                else
                begin
                    exp = bytes_due.pop_front();
                    if (got.out_byte !== exp.out_byte || got.is_header !== exp.is_header ||
                        got.datagram_last !== exp.datagram_last ||
                        got.run_last !== exp.run_last)
                        report_mismatch("byte mismatch", exp, got);
                end
                if (results_seen % 64 == 0)
                    sink_quiet = ($urandom_range(0, 3) == 0);
                stall = draw_gap(sink_quiet);
                take_ready      <= (stall == 0);
                sink_stall_left <= stall;
            end
            else if (!take_ready)
            begin
                // Hold ready low for the drawn stall, then raise it
                if (sink_stall_left <= 1)
                    take_ready <= 1'b1;
                else
                    sink_stall_left <= sink_stall_left - 1;
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d bytes still due", cycle_count,
                     bytes_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Drop bytes before any frame, on an empty frame start, and after that empty start
    task automatic test_outside_frame_drops();
        send_one(request_of(8'hFF, 1'b0, 24'hFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF));
        send_one(request_of(8'hAA, 1'b1, 24'h000000, 32'hFFFFFFFF, 8'hFF, 8'hFF));
        send_one(request_of(8'h00, 1'b0, 24'h000000, 32'h00000000, 8'h00, 8'h00));
    endtask

    // Drive metadata and payload to their extremes in short frames
    task automatic test_field_extremes();
        send_one(request_of(8'h00, 1'b1, 24'd1, 32'hFFFFFFFF, 8'hFF, 8'hFF));
        send_one(request_of(8'hFF, 1'b1, 24'd3, 32'h00000000, 8'h00, 8'h00));
        send_one(request_of(8'h00, 1'b0, 24'hFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF));
        send_one(request_of(8'h5A, 1'b0, 24'h000000, 32'h00000000, 8'h00, 8'h00));
        send_one(request_of(8'h80, 1'b1, 24'd1, 32'h80000001, 8'h01, 8'h01));
        send_one(request_of(8'h7F, 1'b0, 24'd5, 32'h00000001, 8'h01, 8'h00));
    endtask

    // Abandon unfinished frames with a new start, including an empty one
    task automatic test_frame_abandon();
        send_one(request_of(8'h11, 1'b1, 24'hFFFFFF, 32'h12345678, 8'h00, 8'h01));
        send_one(request_of(8'h22, 1'b0, 24'h000000, 32'h00000000, 8'h00, 8'h00));
        send_one(request_of(8'h33, 1'b0, 24'h000000, 32'h00000000, 8'h00, 8'h00));
        send_one(request_of(8'h44, 1'b1, 24'd2, 32'h9ABCDEF0, 8'h01, 8'h00));
        send_one(request_of(8'h55, 1'b0, 24'd0, 32'h00000000, 8'h00, 8'h00));
        send_one(request_of(8'h66, 1'b1, 24'd1401, 32'h0000FFFF, 8'h01, 8'h01));
        send_one(request_of(8'h77, 1'b0, 24'd0, 32'h00000000, 8'h00, 8'h00));
        send_one(request_of(8'h88, 1'b1, 24'd0, 32'hDEADBEEF, 8'h02, 8'h03));
        send_one(request_of(8'h99, 1'b0, 24'd0, 32'h00000000, 8'h00, 8'h00));
    endtask

    // Check chunk totals and lengths around the chunk size, two bytes per frame
    task automatic test_chunk_boundaries();
        send_frame(24'(CHUNK - 1), 2);
        send_frame(24'(CHUNK), 2);
        send_frame(24'(CHUNK + 1), 2);
        send_frame(24'(2 * CHUNK), 2);
        send_frame(24'(2 * CHUNK + 1), 2);
        send_frame(24'hFFFFFF, 2);
    endtask

    // Mostly well-formed frames, with abandoned frames, stray bytes and empty starts
    task automatic test_random_traffic();
        int          useful;
        int          pick;
        int          count;
        int          produced;
        logic [23:0] size;

        useful = 0;
        while (useful < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                size = (pick < 60) ? 24'($urandom_range(1, 40)) : 24'($urandom_range(1, 3));
                count = int'(size);
            end
            else if (pick < 80)
            begin
                size = 24'($urandom);
                if (size == 0)
                    size = 24'd1;
                count = $urandom_range(1, 12);
                if (count > int'(size))
                    count = int'(size);
            end
            else if (pick < 90)
            begin
                size = '0;
                count = $urandom_range(1, 3);
            end
            else
            begin
                size = '0;
                count = 1;
            end

            for (int i = 0; i < count; i++)
            begin
                // Stray bytes never start a frame; the rest start on their first byte
                send_request(random_request((pick < 80 || pick >= 90) && i == 0, size),
                             produced);
                if (produced > 0)
                    useful++;
            end
        end
    endtask

    initial
    begin
        frame_open      = 1'b0;
        bytes_remaining = '0;
        chunk_fill      = '0;
        seg_index       = '0;
        chunk_count     = '0;
        tag_frame       = '0;
        tag_stream      = '0;
        tag_mode        = '0;
        src_quiet       = 1'b0;
        sink_quiet      = 1'b0;
        sink_stall_left = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_outside_frame_drops();
        test_field_extremes();
        test_frame_abandon();
        test_chunk_boundaries();
        test_random_traffic();

        // Stop requesting, drain the predicted bytes, then watch for strays
        push_valid <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (bytes_due.size() != 0)
            mismatch_count++;

        $display("Sent %0d payload requests (%0d dropped) across %0d frames and %0d datagrams",
                 requests_sent, requests_dropped, frames_opened, datagrams_due);
        $display("Checked %0d output bytes in %0d cycles, %0d mismatches",
                 results_seen, cycle_count, mismatch_count);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
